[sv/bmf_pkg.sv]
// Shared types and constants of the batch median filter.
package bmf_pkg;

	localparam int MAX_WINDOW_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int WINDOW_BITS = 5;
	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 5'd5;

	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 2;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW_LENGTH = 2'd0;

	// Status that one cell hands to its right-hand neighbour.
	typedef struct packed {
		logic gt;     // holds a valid sample above the incoming one
		logic valid;  // holds a sample of the current batch
	} bmf_link_t;

endpackage

[sv/bmf_cell.sv]
// One cell of the sorted insertion chain: a sample register and its valid flag.
module bmf_cell #(
	parameter int SAMPLE_BITS = bmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   insert,
	input  logic                   flush,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [SAMPLE_BITS-1:0] left_value,
	input  bmf_pkg::bmf_link_t     left_link,
	output logic [SAMPLE_BITS-1:0] value,
	output bmf_pkg::bmf_link_t     link
);

	logic [SAMPLE_BITS-1:0] value_q;
	logic                   valid_q;
	logic                   gt;
	logic                   take_left;
	logic                   take_sample;

	assign gt = valid_q && (value_q > sample);

	// A larger sample on the left moves right one place; the new sample lands
	// in the first cell that holds something larger, or at the end of the run.
	assign take_left   = left_link.gt;
	assign take_sample = !left_link.gt && (gt || (!valid_q && left_link.valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flush) begin
			valid_q <= 1'b0;
		end else if (insert) begin
			valid_q <= valid_q || left_link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (insert && take_left) begin
			value_q <= left_value;
		end else if (insert && take_sample) begin
			value_q <= sample;
		end
	end

	assign value      = value_q;
	assign link.gt    = gt;
	assign link.valid = valid_q;

endmodule

[sv/batch_median_filter.sv]
// Top level of the batch median filter: register port, insertion chain and output stage.
//
// Usage: samples arrive as beats on the input channel (in_valid, in_ready,
// sample). Each beat is placed into its sorted position in a chain of cells in
// the cycle it is accepted. When the beat that completes a batch of
// window_length samples arrives, the block reads the middle cell, or the two
// middle cells, in its emit state and loads twice the median into the output
// register, which drives the output channel (out_valid, out_ready,
// median_doubled). The chain is then emptied for the next batch.
// Throughput: one sample per cycle while collecting; after a batch-closing beat
// the input waits in the emit state, as the median taps are read from the chain
// registers after the insertion; the emit state lasts until the output register is free.
// If the receiver stalls, the result waits in the output register and the next
// batch is already collected; once a second closing beat has been accepted, the
// input waits until the first result is taken. window_length is written over the
// APB port at address 0; values 0 act as 1 and values above MAX_WINDOW act as MAX_WINDOW.
// Reset empties the chain, drops any pending result and sets window_length to 5.
module batch_median_filter #(
	parameter int MAX_WINDOW  = bmf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = bmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bmf_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [bmf_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [bmf_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [SAMPLE_BITS-1:0]             sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [SAMPLE_BITS:0]               median_doubled
);

	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int CMPW = (CW > bmf_pkg::WINDOW_BITS) ? CW : bmf_pkg::WINDOW_BITS;

	localparam logic ST_COLLECT = 1'b0;
	localparam logic ST_EMIT    = 1'b1;

	logic [bmf_pkg::WINDOW_BITS-1:0] window_q;
	logic                            state_q;
	logic [CW-1:0]                   count_q;
	logic                            out_valid_q;
	logic [SAMPLE_BITS:0]            median_q;

	logic [CMPW-1:0]        win_ext;
	logic [CMPW-1:0]        eff_len;
	logic [CW-1:0]          count_inc;
	logic                   closing;
	logic                   accept;
	logic                   emit;
	logic [CW-1:0]          half;
	logic [SAMPLE_BITS-1:0] tap_a;
	logic [SAMPLE_BITS-1:0] tap_b;

	logic [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW+1];
	bmf_pkg::bmf_link_t     cell_link  [MAX_WINDOW+1];
	logic [MAX_WINDOW-1:0]  cell_valid;

	// Register port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= bmf_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr == bmf_pkg::ADDR_WINDOW_LENGTH)) begin
			window_q <= pwdata[bmf_pkg::WINDOW_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == bmf_pkg::ADDR_WINDOW_LENGTH)
		? {{(bmf_pkg::APB_DATA_BITS - bmf_pkg::WINDOW_BITS){1'b0}}, window_q}
		: '0;

	// Effective batch length, clamped to 1..MAX_WINDOW.
	assign win_ext = CMPW'(window_q);
	always_comb begin
		if (win_ext == '0) begin
			eff_len = CMPW'(1);
		end else if (win_ext > CMPW'(MAX_WINDOW)) begin
			eff_len = CMPW'(MAX_WINDOW);
		end else begin
			eff_len = win_ext;
		end
	end

	assign count_inc = count_q + CW'(1);
	assign closing   = CMPW'(count_inc) >= eff_len;
	assign in_ready  = (state_q == ST_COLLECT);
	assign accept    = in_valid && in_ready;
	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						count_q <= count_inc;
						if (closing) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit) begin
						count_q <= '0;
						state_q <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// Insertion chain. The left edge behaves as a filled cell holding nothing larger.
	assign cell_value[0]      = '0;
	assign cell_link[0].gt    = 1'b0;
	assign cell_link[0].valid = 1'b1;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		bmf_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.insert     (accept),
			.flush      (emit),
			.sample     (sample),
			.left_value (cell_value[i]),
			.left_link  (cell_link[i]),
			.value      (cell_value[i+1]),
			.link       (cell_link[i+1])
		);
		assign cell_valid[i] = cell_link[i+1].valid;
	end

	// Median taps: the middle cell twice for an odd count, else the two middle cells.
	assign half = count_q >> 1;
	always_comb begin
		tap_a = '0;
		tap_b = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (CW'(i) == half) begin
				tap_a = tap_a | cell_value[i+1];
			end
			if ((count_q[0] && (CW'(i) == half)) || (!count_q[0] && (CW'(i + 1) == half))) begin
				tap_b = tap_b | cell_value[i+1];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			median_q <= {1'b0, tap_a} + {1'b0, tap_b};
		end
	end

	assign out_valid      = out_valid_q;
	assign median_doubled = median_q;

	// The filled cells always form a run whose length is the batch count.
	a_fill_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("chain fill does not match batch count");

	a_open_beat_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !closing) |=> (count_q == $past(count_inc)) && (state_q == ST_COLLECT))
		else $error("non-closing beat did not advance the batch count");

	a_close_goes_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && closing) |=> (state_q == ST_EMIT))
		else $error("closing beat did not start the median read");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result appeared without a closed batch");

	a_emit_empties: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (count_q == '0) && (cell_valid == '0))
		else $error("chain not emptied after a result was taken");

endmodule

[tb/batch_median_filter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the batch median filter with its own median predictor.
module batch_median_filter_tb;

	localparam int MAX_WINDOW     = bmf_pkg::MAX_WINDOW_DEF;
	localparam int SAMPLE_BITS    = bmf_pkg::SAMPLE_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIRECTED_MAX   = 40;
	localparam int ITEMS_PER_PASS = 135;

	typedef enum logic [1:0] {
		STEP_SET_WINDOW,
		STEP_SAMPLE,
		STEP_SAMPLE_KNOWN
	} step_kind_t;

	typedef struct packed {
		step_kind_t             kind;
		logic [SAMPLE_BITS-1:0] value;
		logic [SAMPLE_BITS:0]   median2;
	} step_t;

	logic                              clk            = 1'b0;
	logic                              arst_n         = 1'b0;
	logic                              psel           = 1'b0;
	logic                              penable        = 1'b0;
	logic                              pwrite         = 1'b0;
	logic [bmf_pkg::APB_ADDR_BITS-1:0] paddr          = '0;
	logic [bmf_pkg::APB_DATA_BITS-1:0] pwdata         = '0;
	logic [bmf_pkg::APB_DATA_BITS-1:0] prdata;
	logic                              pready;
	logic                              in_valid       = 1'b0;
	logic                              in_ready;
	logic [SAMPLE_BITS-1:0]            sample         = '0;
	logic                              out_valid;
	logic                              out_ready      = 1'b0;
	logic [SAMPLE_BITS:0]              median_doubled;

	// Predictor state: the current batch in ascending order and the length register.
	logic [SAMPLE_BITS-1:0]          ordered [MAX_WINDOW];
	int unsigned                     held = 0;
	logic [bmf_pkg::WINDOW_BITS-1:0] window_reg = bmf_pkg::WINDOW_RESET;

	logic [SAMPLE_BITS:0] medians_due [$];
	step_t                directed_steps [$];
	int                   mismatches = 0;
	int                   stalled_cycles = 0;
	int                   sender_idle_pct = 23;
	int                   receiver_idle_pct = 86;

	batch_median_filter DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.median_doubled (median_doubled)
	);

	always #4 clk = ~clk;

	// Inserts one sample into the sorted batch; returns 1 when the batch closes.
	function automatic bit absorb_sample(input logic [SAMPLE_BITS-1:0] s,
			output logic [SAMPLE_BITS:0] median2);
		int unsigned pos;
		int unsigned span;
		int unsigned half;
		span = (window_reg == 0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg);
		pos = held;
		while (pos > 0 && ordered[pos-1] > s) begin
			ordered[pos] = ordered[pos-1];
			pos--;
		end
		ordered[pos] = s;
		held++;
		median2 = '0;
		if (held < span)
			return 1'b0;
		half = held / 2;
		if (held % 2 == 0)
			median2 = {1'b0, ordered[half-1]} + {1'b0, ordered[half]};
		else
			median2 = {ordered[half], 1'b0};
		held = 0;
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return SAMPLE_BITS'($urandom_range(7));
			default: return SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1));
		endcase
	endfunction

	function automatic logic [bmf_pkg::WINDOW_BITS-1:0] pick_window();
		case ($urandom_range(9))
			0: return '0;
			1: return bmf_pkg::WINDOW_BITS'(MAX_WINDOW);
			2: return bmf_pkg::WINDOW_BITS'($urandom_range(31, MAX_WINDOW + 1));
			default: return bmf_pkg::WINDOW_BITS'($urandom_range(MAX_WINDOW - 1, 1));
		endcase
	endfunction

	function automatic void add_step(input step_kind_t kind, input int value, input int median2);
		step_t st;
		st.kind    = kind;
		st.value   = SAMPLE_BITS'(value);
		st.median2 = (SAMPLE_BITS + 1)'(median2);
		directed_steps.push_back(st);
	endfunction

	// Stops sending and waits until every due median has been taken and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (medians_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [bmf_pkg::WINDOW_BITS-1:0] len);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= bmf_pkg::ADDR_WINDOW_LENGTH;
		pwdata  <= bmf_pkg::APB_DATA_BITS'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		window_reg = len;
	endtask

	// Presents one beat and records the median it closes, if any.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit known,
			input logic [SAMPLE_BITS:0] known_median2);
		logic [SAMPLE_BITS:0] median2;
		int unsigned          gap;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = $urandom_range(4, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		if (absorb_sample(s, median2))
			medians_due.push_back(known ? known_median2 : median2);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin : check_medians
		logic [SAMPLE_BITS:0] due;
		if (arst_n && out_valid && out_ready) begin
			if (medians_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected median_doubled %0d", median_doubled);
				mismatches++;
			end else begin
				due = medians_due.pop_front();
				if (median_doubled !== due) begin
					if (mismatches < 10)
						$display("median_doubled: expected %0d, got %0d", due, median_doubled);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles == WATCHDOG_LIMIT) begin
				$display("batch_median_filter: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int          sent;
		int unsigned span;
		int unsigned count;
		logic [bmf_pkg::WINDOW_BITS-1:0] len;

		// After reset the batch holds five samples.
		add_step(STEP_SAMPLE, 0, 0);
		add_step(STEP_SAMPLE, 1023, 0);
		add_step(STEP_SAMPLE, 512, 0);
		add_step(STEP_SAMPLE, 1, 0);
		add_step(STEP_SAMPLE_KNOWN, 1022, 1024);
		// A length of zero behaves as one, so each beat comes back doubled.
		add_step(STEP_SET_WINDOW, 0, 0);
		add_step(STEP_SAMPLE_KNOWN, 1023, 2046);
		add_step(STEP_SAMPLE_KNOWN, 0, 0);
		add_step(STEP_SET_WINDOW, 2, 0);
		add_step(STEP_SAMPLE, 1023, 0);
		add_step(STEP_SAMPLE_KNOWN, 1023, 2046);
		// An oversized length saturates; descending pairs of equal samples.
		add_step(STEP_SET_WINDOW, 31, 0);
		for (int i = 0; i < MAX_WINDOW; i++)
			add_step(STEP_SAMPLE, ((MAX_WINDOW - 1 - i) / 2) * 140, 0);
		// Shortening the length mid-batch closes it over every sample held.
		add_step(STEP_SET_WINDOW, 3, 0);
		add_step(STEP_SAMPLE, 5, 0);
		add_step(STEP_SAMPLE, 5, 0);
		add_step(STEP_SET_WINDOW, 1, 0);
		add_step(STEP_SAMPLE_KNOWN, 900, 10);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_SET_WINDOW) begin
				drain();
				write_window(bmf_pkg::WINDOW_BITS'(directed_steps[i].value));
			end else begin
				send_sample(directed_steps[i].value, directed_steps[i].kind == STEP_SAMPLE_KNOWN,
					directed_steps[i].median2);
			end
		end

		for (int pass = 0; pass < 3; pass++) begin
			sender_idle_pct   = (pass == 0) ? 23 : (pass == 1) ? 86 : 0;
			receiver_idle_pct = (pass == 0) ? 86 : (pass == 1) ? 23 : 0;
			sent = 0;
			while (sent < ITEMS_PER_PASS) begin
				// A partial batch may be left over, so the new length often lands mid-batch.
				len = pick_window();
				drain();
				write_window(len);
				span = (len == 0) ? 1 : ((len > MAX_WINDOW) ? MAX_WINDOW : len);
				count = $urandom_range(2 * span + 1, 1);
				for (int k = 0; k < count; k++)
					send_sample(pick_sample(), 1'b0, '0);
				sent += count;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && medians_due.size() == 0)
			$display("batch_median_filter: match");
		else
			$display("batch_median_filter: mismatch");
		$finish;
	end

endmodule
